@@ hdl/sfk_pkg.sv @@
// Shared types, constants and arithmetic helpers for the six-joint pose pipeline.
`default_nettype none
package sfk_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int OUT_BITS     = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int NSTEP        = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  localparam int FRAC   = 30;
  localparam int VAL_W  = 34;
  localparam int ANG_W  = 34;
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int CODE_W = 40;

  localparam int PADDR_W = 3;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [CODE_W-1:0] code_t;

  typedef val_t mat_t [3][4];

  typedef enum logic [1:0] {
    JNT_A,
    JNT_B,
    JNT_C
  } joint_kind_t;

  typedef struct packed {
    joint_kind_t kind;
    logic        offset;
    logic        bypass;
  } joint_ctl_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] waist_angle;
    logic signed [ANGLE_BITS-1:0] shoulder_angle;
    logic signed [ANGLE_BITS-1:0] elbow_angle;
    logic signed [ANGLE_BITS-1:0] wrist_one_angle;
    logic signed [ANGLE_BITS-1:0] wrist_two_angle;
    logic signed [ANGLE_BITS-1:0] wrist_three_angle;
  } joint_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] x_norm;
    logic [OUT_BITS-1:0] y_norm;
    logic [OUT_BITS-1:0] z_norm;
    logic [OUT_BITS-1:0] roll_norm;
    logic [OUT_BITS-1:0] pitch_norm;
    logic [OUT_BITS-1:0] yaw_norm;
  } pose_item_t;

  localparam logic REG_ARM_ONLY = 1'b0;

  localparam logic [31:0] ARC_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam val_t  ONE_Q   = val_t'(64'd1 << FRAC);
  localparam val_t  GAIN_Q  = val_t'(64'd652032874);
  localparam ang_t  QUARTER = ang_t'(64'h4000_0000);
  localparam code_t OUT_MAX = code_t'((64'd1 << OUT_BITS) - 64'd1);
  localparam code_t TURN    = code_t'(64'd1 << 32);
  localparam code_t THREE_Q = code_t'(64'd3 << 30);

  localparam int ROT_LAT = NSTEP + 2;
  localparam int VEC_LAT = NSTEP + 2;
  localparam int DLY_POS = 2 * VEC_LAT + ROT_LAT + 2;
  localparam int DLY_ANG = VEC_LAT + ROT_LAT + 2;
  localparam int DLY_ACC = VEC_LAT + ROT_LAT;
  localparam int DLY_A02 = DLY_ACC + 2;
  localparam int LAT     = 2 * ROT_LAT + 2 * VEC_LAT + 15;

  function automatic val_t qround(input sum_t v);
    sum_t t;
    t = v + sum_t'(64'd1 << (FRAC - 1));
    return val_t'(t >>> FRAC);
  endfunction

  function automatic logic [OUT_BITS-1:0] clamp_code(input code_t v);
    logic [OUT_BITS-1:0] r;
    if (v[CODE_W-1]) begin
      r = '0;
    end else if (v > OUT_MAX) begin
      r = '1;
    end else begin
      r = v[OUT_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/sfk_if.sv @@
// Valid/ready channel interfaces for joint vectors and pose results.
`default_nettype none
interface sfk_joint_if;
  import sfk_pkg::*;
  logic        valid;
  logic        ready;
  joint_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfk_pose_if;
  import sfk_pkg::*;
  logic       valid;
  logic       ready;
  pose_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/sfk_rot.sv @@
// Pipelined rotation-mode CORDIC giving cosine and sine of a 32-bit binary angle.
`default_nettype none
module sfk_rot import sfk_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] angle,
  output val_t        cosine,
  output val_t        sine
);

  logic [31:0] shifted;
  val_t        x [NSTEP+1];
  val_t        y [NSTEP+1];
  ang_t        z [NSTEP+1];
  logic [1:0]  quad [NSTEP+1];

  assign shifted = angle + 32'h2000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= GAIN_Q;
      y[0]    <= '0;
      z[0]    <= ang_t'({2'b00, shifted[29:0]}) - ang_t'(32'h2000_0000);
      quad[0] <= shifted[31:30];
      for (int i = 0; i < NSTEP; i++) begin
        if (!z[i][ANG_W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ang_t'(ARC_TAB[i]);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ang_t'(ARC_TAB[i]);
        end
        quad[i+1] <= quad[i];
      end
      unique case (quad[NSTEP])
        2'd1: begin
          cosine <= -y[NSTEP];
          sine   <= x[NSTEP];
        end
        2'd2: begin
          cosine <= -x[NSTEP];
          sine   <= -y[NSTEP];
        end
        2'd3: begin
          cosine <= y[NSTEP];
          sine   <= -x[NSTEP];
        end
        2'd0: begin
          cosine <= x[NSTEP];
          sine   <= y[NSTEP];
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/sfk_vec.sv @@
// Pipelined vectoring-mode CORDIC giving atan2(y, x) as a binary angle.
`default_nettype none
module sfk_vec import sfk_pkg::*; (
  input  logic clk,
  input  logic en,
  input  val_t xin,
  input  val_t yin,
  output ang_t angle
);

  val_t x [NSTEP+1];
  val_t y [NSTEP+1];
  ang_t z [NSTEP+1];
  logic nil [NSTEP+1];

  always_ff @(posedge clk) begin
    if (en) begin
      nil[0] <= (xin == '0) && (yin == '0);
      if (xin[VAL_W-1]) begin
        if (!yin[VAL_W-1]) begin
          x[0] <= yin;
          y[0] <= -xin;
          z[0] <= QUARTER;
        end else begin
          x[0] <= -yin;
          y[0] <= xin;
          z[0] <= -QUARTER;
        end
      end else begin
        x[0] <= xin;
        y[0] <= yin;
        z[0] <= '0;
      end
      for (int i = 0; i < NSTEP; i++) begin
        if (!y[i][VAL_W-1]) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ang_t'(ARC_TAB[i]);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ang_t'(ARC_TAB[i]);
        end
        nil[i+1] <= nil[i];
      end
      angle <= nil[NSTEP] ? '0 : z[NSTEP];
    end
  end

endmodule
`default_nettype wire

@@ hdl/sfk_joint.sv @@
// Two-stage multiply and round of the running pose by one joint transform.
`default_nettype none
module sfk_joint import sfk_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  joint_ctl_t ctl,
  input  mat_t       acc_in,
  input  val_t       c,
  input  val_t       s,
  output mat_t       acc_out
);

  val_t  ch;
  val_t  sh;
  prod_t m_ac [3];
  prod_t m_bs [3];
  prod_t m_as [3];
  prod_t m_bc [3];
  prod_t m_ah [3];
  prod_t m_bh [3];
  mat_t  held;

  assign ch = c >>> 1;
  assign sh = s >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      held <= acc_in;
      for (int r = 0; r < 3; r++) begin
        m_ac[r] <= acc_in[r][0] * c;
        m_bs[r] <= acc_in[r][1] * s;
        m_as[r] <= acc_in[r][0] * s;
        m_bc[r] <= acc_in[r][1] * c;
        m_ah[r] <= acc_in[r][0] * ch;
        m_bh[r] <= acc_in[r][1] * sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl.bypass) begin
        acc_out <= held;
      end else begin
        for (int r = 0; r < 3; r++) begin
          acc_out[r][0] <= qround(sum_t'(m_ac[r]) + sum_t'(m_bs[r]));
          unique case (ctl.kind)
            JNT_A: begin
              acc_out[r][1] <= held[r][2];
              acc_out[r][2] <= qround(sum_t'(m_as[r]) - sum_t'(m_bc[r]));
              acc_out[r][3] <= ctl.offset ?
                               held[r][3] + ((held[r][2] + val_t'(1)) >>> 1) : held[r][3];
            end
            JNT_B: begin
              acc_out[r][1] <= -held[r][2];
              acc_out[r][2] <= qround(sum_t'(m_bc[r]) - sum_t'(m_as[r]));
              acc_out[r][3] <= held[r][3];
            end
            default: begin
              acc_out[r][1] <= qround(sum_t'(m_bc[r]) - sum_t'(m_as[r]));
              acc_out[r][2] <= held[r][2];
              acc_out[r][3] <= ctl.offset ?
                               held[r][3] + qround(sum_t'(m_ah[r]) + sum_t'(m_bh[r])) :
                               held[r][3];
            end
          endcase
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/six_joint_forward_kinematics.sv @@
// Throughput: one joint vector per cycle; the pipeline holds whole while a result stalls.
// The path length is set by two rotation and two vectoring CORDIC pipelines in series
// plus six joint product stages.
// Reset (synchronous, active high) clears the valid pipeline and arm_only.
`default_nettype none
module six_joint_forward_kinematics import sfk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sfk_joint_if.sink          joints,
  sfk_pose_if.source         pose,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic                         arm_only;
  logic                         en;
  logic [LAT:1]                 vld;
  logic signed [ANGLE_BITS-1:0] ang_in [6];
  logic [31:0]                  rot_ang [6];
  val_t                         cj [6];
  val_t                         sj [6];
  joint_ctl_t                   jctl [6];
  mat_t                         ident;
  mat_t                         acc_chain [6];
  mat_t                         fin;
  ang_t                         roll;
  ang_t                         yaw;
  ang_t                         pitch;
  val_t                         cr;
  val_t                         sr;
  logic [31:0]                  roll_turn;
  code_t                        yaw_v;
  code_t                        yaw_w;
  logic [OUT_BITS-1:0]          pos_tap [3][DLY_POS];
  logic [OUT_BITS-1:0]          roll_tap [DLY_ANG];
  logic [OUT_BITS-1:0]          yaw_tap [DLY_ANG];
  val_t                         a00_tap [DLY_ACC];
  val_t                         a01_tap [DLY_ACC];
  val_t                         na02_tap [DLY_A02];
  prod_t                        pm0;
  prod_t                        pm1;
  val_t                         px;
  pose_item_t                   out_reg;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ARM_ONLY) ? {31'b0, arm_only} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_only <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ARM_ONLY)) begin
      arm_only <= pwdata[0];
    end
  end

  assign en           = !vld[LAT] || pose.ready;
  assign joints.ready = en;
  assign pose.valid   = vld[LAT];
  assign pose.data    = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], joints.valid};
    end
  end

  assign ang_in[0] = joints.data.waist_angle;
  assign ang_in[1] = joints.data.shoulder_angle;
  assign ang_in[2] = joints.data.elbow_angle;
  assign ang_in[3] = joints.data.wrist_one_angle;
  assign ang_in[4] = joints.data.wrist_two_angle;
  assign ang_in[5] = joints.data.wrist_three_angle;

  assign rot_ang[0] = {ang_in[0], {(32-ANGLE_BITS){1'b0}}};

  for (genvar j = 1; j < 6; j++) begin : g_skew
    logic [ANGLE_BITS-1:0] tap [2*j];
    always_ff @(posedge clk) begin
      if (en) begin
        tap[0] <= ang_in[j];
        for (int k = 1; k < 2 * j; k++) begin
          tap[k] <= tap[k-1];
        end
      end
    end
    assign rot_ang[j] = {tap[2*j-1], {(32-ANGLE_BITS){1'b0}}};
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        ident[r][k] = (r == k) ? ONE_Q : '0;
      end
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_joint
    assign jctl[j].kind   = (j == 0 || j == 3) ? JNT_A : ((j == 2 || j == 4) ? JNT_B : JNT_C);
    assign jctl[j].offset = (j == 1 || j == 3);
    assign jctl[j].bypass = arm_only && (j >= 3);

    sfk_rot u_rot (
      .clk    (clk),
      .en     (en),
      .angle  (rot_ang[j]),
      .cosine (cj[j]),
      .sine   (sj[j])
    );

    if (j == 0) begin : g_first
      sfk_joint u_joint (
        .clk     (clk),
        .en      (en),
        .ctl     (jctl[j]),
        .acc_in  (ident),
        .c       (cj[j]),
        .s       (sj[j]),
        .acc_out (acc_chain[j])
      );
    end else begin : g_next
      sfk_joint u_joint (
        .clk     (clk),
        .en      (en),
        .ctl     (jctl[j]),
        .acc_in  (acc_chain[j-1]),
        .c       (cj[j]),
        .s       (sj[j]),
        .acc_out (acc_chain[j])
      );
    end
  end

  assign fin = acc_chain[5];

  sfk_vec u_roll (
    .clk   (clk),
    .en    (en),
    .xin   (fin[0][0]),
    .yin   (fin[0][1]),
    .angle (roll)
  );

  sfk_vec u_yaw (
    .clk   (clk),
    .en    (en),
    .xin   (fin[2][2]),
    .yin   (fin[1][2]),
    .angle (yaw)
  );

  sfk_rot u_roll_rot (
    .clk    (clk),
    .en     (en),
    .angle  (roll[31:0]),
    .cosine (cr),
    .sine   (sr)
  );

  sfk_vec u_pitch (
    .clk   (clk),
    .en    (en),
    .xin   (px),
    .yin   (na02_tap[DLY_A02-1]),
    .angle (pitch)
  );

  assign roll_turn = roll[31:0] + 32'h8000_0000;

  always_comb begin
    yaw_v = code_t'(yaw) + THREE_Q;
    yaw_w = (yaw_v > TURN) ? yaw_v - TURN : yaw_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        pos_tap[r][0] <= clamp_code((code_t'(fin[r][3]) + code_t'(ONE_Q)) >>> (FRAC+1-OUT_BITS));
        for (int k = 1; k < DLY_POS; k++) begin
          pos_tap[r][k] <= pos_tap[r][k-1];
        end
      end
      roll_tap[0] <= roll_turn[31 -: OUT_BITS];
      yaw_tap[0]  <= clamp_code(yaw_w >>> (32-OUT_BITS));
      for (int k = 1; k < DLY_ANG; k++) begin
        roll_tap[k] <= roll_tap[k-1];
        yaw_tap[k]  <= yaw_tap[k-1];
      end
      a00_tap[0] <= fin[0][0];
      a01_tap[0] <= fin[0][1];
      for (int k = 1; k < DLY_ACC; k++) begin
        a00_tap[k] <= a00_tap[k-1];
        a01_tap[k] <= a01_tap[k-1];
      end
      na02_tap[0] <= -fin[0][2];
      for (int k = 1; k < DLY_A02; k++) begin
        na02_tap[k] <= na02_tap[k-1];
      end
      pm0 <= a00_tap[DLY_ACC-1] * cr;
      pm1 <= a01_tap[DLY_ACC-1] * sr;
      px  <= qround(sum_t'(pm0) + sum_t'(pm1));
      out_reg.x_norm     <= pos_tap[0][DLY_POS-1];
      out_reg.y_norm     <= pos_tap[1][DLY_POS-1];
      out_reg.z_norm     <= pos_tap[2][DLY_POS-1];
      out_reg.roll_norm  <= roll_tap[DLY_ANG-1];
      out_reg.pitch_norm <= clamp_code((code_t'(pitch) + code_t'(QUARTER)) >>> (31-OUT_BITS));
      out_reg.yaw_norm   <= yaw_tap[DLY_ANG-1];
    end
  end

endmodule
`default_nettype wire

@@ hdl/sfk_checker.sv @@
// Port-level checks for the pose pipeline, bound to the top level.
`default_nettype none
module sfk_checker import sfk_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input pose_item_t out_data
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind six_joint_forward_kinematics sfk_checker u_sfk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (joints.ready),
  .out_valid (pose.valid),
  .out_ready (pose.ready),
  .out_data  (pose.data)
);
`default_nettype wire
